// ===== hw/rtl/string_to_integer_parser_macros.svh =====
// ----------------------------------------------------------------------------
// string_to_integer_parser_macros.svh
// Assertion macros shared by the parser RTL. Both expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef STRING_TO_INTEGER_PARSER_MACROS_SVH
`define STRING_TO_INTEGER_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define STIP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define STIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/stip_pkg.sv =====
// ----------------------------------------------------------------------------
// stip_pkg
// Types, character codes and helper functions of the string-to-integer parser.
// ----------------------------------------------------------------------------
package stip_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;

    localparam logic [5:0] BASE_AUTO  = 6'd0;
    localparam logic [5:0] BASE_BIN   = 6'd2;
    localparam logic [5:0] BASE_OCT   = 6'd8;
    localparam logic [5:0] BASE_DEC   = 6'd10;
    localparam logic [5:0] BASE_HEX   = 6'd16;
    localparam logic [5:0] BASE_RESET = BASE_DEC;

    localparam logic [6:0] NOT_A_DIGIT = 7'd99;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_B_LO  = 8'h62;
    localparam logic [7:0] CH_B_UP  = 8'h42;

    typedef enum logic [4:0] {
        PH_DONE   = 5'b00001,
        PH_LEAD   = 5'b00010,
        PH_SIGNED = 5'b00100,
        PH_ZERO   = 5'b01000,
        PH_DIGITS = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] character;
        logic       string_start;
    } char_item_t;

    typedef struct packed {
        logic signed [63:0] parsed_value;
        logic [15:0]        consumed_count;
        logic               digits_seen;
        logic               minus_seen;
    } result_item_t;

    typedef struct packed {
        phase_t      phase;
        logic [5:0]  active_base;
        logic [63:0] accumulator;
        logic        negative_flag;
        logic        any_digit_flag;
    } parse_state_t;

    function automatic logic is_blank(input logic [7:0] ch);
        return ch inside {8'd32, [8'd9:8'd13]};
    endfunction

    function automatic logic [6:0] digit_value(input logic [7:0] ch);
        logic [6:0] d;
        case (ch) inside
            [8'h30:8'h39]: d = 7'(ch - 8'h30);
            [8'h61:8'h7A]: d = 7'(ch - 8'h61 + 8'd10);
            [8'h41:8'h5A]: d = 7'(ch - 8'h41 + 8'd10);
            default:       d = NOT_A_DIGIT;
        endcase
        return d;
    endfunction

endpackage

// ===== hw/rtl/string_to_integer_parser.sv =====
// A terminator's result passes the character register, then the result register.
// Throughput: one character per cycle; the radix multiply-add is combinational.
// The character register is the only buffer; it stalls only when a result waits.
// Reset: radix register 10, parser idle (characters ignored until a string start),
// character and result registers empty.
// ----------------------------------------------------------------------------
// string_to_integer_parser
// Streaming text-to-integer converter: at most one result per parsed string.
// ----------------------------------------------------------------------------
`include "string_to_integer_parser_macros.svh"

module string_to_integer_parser #(
    parameter int POSITION_BITS = stip_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   base_we,
    input  logic [5:0]             base_wdata,
    input  logic                   char_valid,
    output logic                   char_ready,
    input  stip_pkg::char_item_t   char_data,
    output logic                   result_valid,
    input  logic                   result_ready,
    output stip_pkg::result_item_t result_data
);

    logic [5:0]              number_base_reg;
    logic                    char_valid_reg;
    stip_pkg::char_item_t    char_reg;
    stip_pkg::parse_state_t  state_reg;
    stip_pkg::parse_state_t  state_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic                    result_valid_reg;
    stip_pkg::result_item_t  result_reg;
    stip_pkg::result_item_t  result_next;
    logic                    emit;
    logic                    proc_fire;

    assign proc_fire = char_valid_reg && (!result_valid_reg || result_ready);
    assign char_ready = !char_valid_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= stip_pkg::BASE_RESET;
        end
        else if (base_we)
        begin
            number_base_reg <= base_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
        end
        else if (char_ready)
        begin
            char_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
        begin
            char_reg <= char_data;
        end
    end

    stip_step #(
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .state_cur   (state_reg),
        .pos_cur     (pos_reg),
        .item        (char_reg),
        .number_base (number_base_reg),
        .state_nxt   (state_next),
        .pos_nxt     (pos_next),
        .emit        (emit),
        .result      (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase          <= stip_pkg::PH_DONE;
            state_reg.active_base    <= '0;
            state_reg.accumulator    <= '0;
            state_reg.negative_flag  <= 1'b0;
            state_reg.any_digit_flag <= 1'b0;
            pos_reg                  <= '0;
        end
        else if (proc_fire)
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (proc_fire && emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && emit)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    `STIP_ASSERT_NOW(a_no_digit_empty,
        result_valid && !result_data.digits_seen,
        result_data.consumed_count == 16'd0 && result_data.parsed_value == 64'sd0,
        "result without digits reports a count or value")
    `STIP_ASSERT_NOW(a_idle_silent,
        proc_fire && state_reg.phase == stip_pkg::PH_DONE && !char_reg.string_start,
        !emit,
        "idle parser produced a result")
    `STIP_ASSERT_NEXT(a_emit_done,
        proc_fire && emit,
        state_reg.phase == stip_pkg::PH_DONE && result_valid_reg,
        "result emitted without ending the parse")
    `STIP_ASSERT_NEXT(a_start_active,
        proc_fire && char_reg.string_start && !emit,
        state_reg.phase != stip_pkg::PH_DONE,
        "string start left the parser idle")

endmodule

// ===== hw/rtl/stip_step.sv =====
// ----------------------------------------------------------------------------
// stip_step
// Next-state and result logic for one character of the parse.
// ----------------------------------------------------------------------------
module stip_step #(
    parameter int POSITION_BITS = stip_pkg::POSITION_BITS_DEFAULT
) (
    input  stip_pkg::parse_state_t  state_cur,
    input  logic [POSITION_BITS-1:0] pos_cur,
    input  stip_pkg::char_item_t    item,
    input  logic [5:0]              number_base,
    output stip_pkg::parse_state_t  state_nxt,
    output logic [POSITION_BITS-1:0] pos_nxt,
    output logic                    emit,
    output stip_pkg::result_item_t  result
);

    stip_pkg::parse_state_t  s;
    logic [POSITION_BITS-1:0] pos;
    logic [6:0]              digit;
    logic                    run_signed;
    logic                    run_digit;
    logic                    adv;
    logic [31:0]             pos_wide;
    logic [7:0]              ch;

    assign ch    = item.character;
    assign digit = stip_pkg::digit_value(ch);

    always_comb
    begin
        s          = state_cur;
        pos        = pos_cur;
        run_signed = 1'b0;
        run_digit  = 1'b0;
        adv        = 1'b0;
        emit       = 1'b0;

        // restart the parse on a start-of-string mark
        if (item.string_start)
        begin
            s.phase          = stip_pkg::PH_LEAD;
            s.active_base    = number_base;
            s.accumulator    = '0;
            s.negative_flag  = 1'b0;
            s.any_digit_flag = 1'b0;
            pos              = '0;
        end

        case (s.phase)
            stip_pkg::PH_LEAD:
            begin
                if (stip_pkg::is_blank(ch))
                begin
                    adv = 1'b1;
                end
                else if (ch == stip_pkg::CH_PLUS || ch == stip_pkg::CH_MINUS)
                begin
                    s.negative_flag = (ch == stip_pkg::CH_MINUS);
                    adv             = 1'b1;
                    s.phase         = stip_pkg::PH_SIGNED;
                end
                else
                begin
                    run_signed = 1'b1;
                end
            end
            stip_pkg::PH_SIGNED:
            begin
                run_signed = 1'b1;
            end
            stip_pkg::PH_ZERO:
            begin
                if ((ch == stip_pkg::CH_X_LO || ch == stip_pkg::CH_X_UP) &&
                    (s.active_base == stip_pkg::BASE_AUTO ||
                     s.active_base == stip_pkg::BASE_HEX))
                begin
                    s.active_base = stip_pkg::BASE_HEX;
                    adv           = 1'b1;
                    s.phase       = stip_pkg::PH_DIGITS;
                end
                else if ((ch == stip_pkg::CH_B_LO || ch == stip_pkg::CH_B_UP) &&
                         (s.active_base == stip_pkg::BASE_AUTO ||
                          s.active_base == stip_pkg::BASE_BIN))
                begin
                    s.active_base = stip_pkg::BASE_BIN;
                    adv           = 1'b1;
                    s.phase       = stip_pkg::PH_DIGITS;
                end
                else
                begin
                    // the lone zero was a digit; in auto mode it means octal
                    if (s.active_base == stip_pkg::BASE_AUTO)
                    begin
                        s.active_base = stip_pkg::BASE_OCT;
                    end
                    s.accumulator    = '0;
                    s.any_digit_flag = 1'b1;
                    s.phase          = stip_pkg::PH_DIGITS;
                    run_digit        = 1'b1;
                end
            end
            stip_pkg::PH_DIGITS:
            begin
                run_digit = 1'b1;
            end
            default:
            begin
                // idle: drop the character
            end
        endcase

        if (run_signed)
        begin
            if (ch == stip_pkg::CH_ZERO &&
                (s.active_base == stip_pkg::BASE_AUTO ||
                 s.active_base == stip_pkg::BASE_BIN ||
                 s.active_base == stip_pkg::BASE_HEX))
            begin
                adv     = 1'b1;
                s.phase = stip_pkg::PH_ZERO;
            end
            else
            begin
                if (s.active_base == stip_pkg::BASE_AUTO)
                begin
                    s.active_base = stip_pkg::BASE_DEC;
                end
                s.phase   = stip_pkg::PH_DIGITS;
                run_digit = 1'b1;
            end
        end

        if (run_digit)
        begin
            if (digit < 7'(s.active_base))
            begin
                s.accumulator    = 64'(s.accumulator * 64'(s.active_base)) + 64'(digit);
                s.any_digit_flag = 1'b1;
                adv              = 1'b1;
            end
            else
            begin
                emit    = 1'b1;
                s.phase = stip_pkg::PH_DONE;
            end
        end

        // saturate the position count
        if (adv && pos != '1)
        begin
            pos = pos + 1'b1;
        end
    end

    assign state_nxt = s;
    assign pos_nxt   = pos;
    assign pos_wide  = 32'(pos);

    always_comb
    begin
        result.parsed_value = s.negative_flag ? $signed(64'd0 - s.accumulator)
                                              : $signed(s.accumulator);
        if (!s.any_digit_flag)
        begin
            result.consumed_count = '0;
        end
        else if (pos_wide > 32'h0000_FFFF)
        begin
            result.consumed_count = 16'hFFFF;
        end
        else
        begin
            result.consumed_count = pos_wide[15:0];
        end
        result.digits_seen = s.any_digit_flag;
        result.minus_seen  = s.negative_flag;
    end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks string_to_integer_parser: a short table of hand-written strings, one
// long string that wraps the 64-bit value, then random strings, broken
// strings and noise under several radix settings and idle patterns.
// Every result is compared field by field against a table row or an in-bench parse model.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RESET_CYCLES  = 8;
    localparam int PHASE_CHARS   = 110;
    localparam int LONG_DIGITS   = 100;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_A_LO  = 8'h61;

    typedef struct {
        bit                     load_base;
        logic [5:0]             base;
        stip_pkg::char_item_t   item;
        bit                     typed;
        stip_pkg::result_item_t want;
    } dir_row_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   base_we      = 1'b0;
    logic [5:0]             base_wdata   = stip_pkg::BASE_RESET;
    logic                   char_valid   = 1'b0;
    logic                   char_ready;
    stip_pkg::char_item_t   char_data    = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    stip_pkg::result_item_t result_data;

    // parse model state
    logic [5:0]       radix_reg = stip_pkg::BASE_RESET;
    stip_pkg::phase_t pr_phase  = stip_pkg::PH_DONE;
    logic [5:0]       pr_base   = '0;
    logic [63:0]      pr_acc    = '0;
    logic             pr_neg    = 1'b0;
    logic             pr_any    = 1'b0;
    logic [15:0]      pr_pos    = '0;

    stip_pkg::result_item_t pending_results [$];
    int                     error_count    = 0;
    int                     parsed_chars   = 0;
    int                     cycle_count    = 0;
    int                     send_idle_pct  = 0;
    int                     recv_stall_pct = 0;
    bit                     hold_req       = 1'b0;
    bit                     row_typed      = 1'b0;
    stip_pkg::result_item_t row_want       = '0;

    int send_pct_by_mode [4] = '{0, 71, 0, 16};
    int recv_pct_by_mode [4] = '{0, 0, 71, 16};
    logic [5:0] phase_bases [10] = '{stip_pkg::BASE_RESET, stip_pkg::BASE_AUTO,
                                     stip_pkg::BASE_HEX, stip_pkg::BASE_BIN,
                                     stip_pkg::BASE_OCT, 6'd36, 6'd1, 6'd63, 6'd37,
                                     stip_pkg::BASE_AUTO};

    dir_row_t dir_table [26] = '{
        '{1'b0, stip_pkg::BASE_DEC, '{"A", 1'b0}, 1'b0, '0},
        '{1'b0, stip_pkg::BASE_DEC, '{CH_TAB, 1'b1}, 1'b0, '0},
        '{1'b0, stip_pkg::BASE_DEC, '{stip_pkg::CH_MINUS, 1'b0}, 1'b0, '0},
        '{1'b0, stip_pkg::BASE_DEC, '{"4", 1'b0}, 1'b0, '0},
        '{1'b0, stip_pkg::BASE_DEC, '{"2", 1'b0}, 1'b0, '0},
        '{1'b0, stip_pkg::BASE_DEC, '{CH_NUL, 1'b0}, 1'b1, '{-64'sd42, 16'd4, 1'b1, 1'b1}},
        '{1'b0, stip_pkg::BASE_DEC, '{stip_pkg::CH_PLUS, 1'b1}, 1'b0, '0},
        '{1'b0, stip_pkg::BASE_DEC, '{"#", 1'b0}, 1'b1, '{64'sd0, 16'd0, 1'b0, 1'b0}},
        '{1'b0, stip_pkg::BASE_DEC, '{stip_pkg::CH_MINUS, 1'b1}, 1'b0, '0},
        '{1'b0, stip_pkg::BASE_DEC, '{"z", 1'b0}, 1'b1, '{64'sd0, 16'd0, 1'b0, 1'b1}},
        '{1'b0, stip_pkg::BASE_DEC, '{"5", 1'b0}, 1'b0, '0},
        '{1'b0, stip_pkg::BASE_DEC, '{stip_pkg::CH_ZERO, 1'b1}, 1'b0, '0},
        '{1'b0, stip_pkg::BASE_DEC, '{8'hFF, 1'b0}, 1'b1, '{64'sd0, 16'd1, 1'b1, 1'b0}},
        '{1'b0, stip_pkg::BASE_DEC, '{"9", 1'b1}, 1'b0, '0},
        '{1'b0, stip_pkg::BASE_DEC, '{"7", 1'b1}, 1'b0, '0},
        '{1'b0, stip_pkg::BASE_DEC, '{CH_LF, 1'b0}, 1'b0, '0},
        '{1'b1, stip_pkg::BASE_AUTO, '{stip_pkg::CH_ZERO, 1'b1}, 1'b0, '0},
        '{1'b0, stip_pkg::BASE_AUTO, '{stip_pkg::CH_X_LO, 1'b0}, 1'b0, '0},
        '{1'b0, stip_pkg::BASE_AUTO, '{"g", 1'b0}, 1'b1, '{64'sd0, 16'd0, 1'b0, 1'b0}},
        '{1'b0, stip_pkg::BASE_AUTO, '{stip_pkg::CH_ZERO, 1'b1}, 1'b0, '0},
        '{1'b0, stip_pkg::BASE_AUTO, '{"7", 1'b0}, 1'b0, '0},
        '{1'b0, stip_pkg::BASE_AUTO, '{"8", 1'b0}, 1'b0, '0},
        '{1'b1, 6'd1, '{stip_pkg::CH_ZERO, 1'b1}, 1'b0, '0},
        '{1'b0, 6'd1, '{"1", 1'b0}, 1'b0, '0},
        '{1'b1, 6'd63, '{"z", 1'b1}, 1'b0, '0},
        '{1'b0, 6'd63, '{"~", 1'b0}, 1'b0, '0}
    };

    string_to_integer_parser u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .base_we      (base_we),
        .base_wdata   (base_wdata),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_data    (char_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic [6:0] char_digit(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9")
            return 7'(ch - "0");
        if (ch >= "a" && ch <= "z")
            return 7'(ch - "a" + 8'd10);
        if (ch >= "A" && ch <= "Z")
            return 7'(ch - "A" + 8'd10);
        return stip_pkg::NOT_A_DIGIT;
    endfunction

    function automatic void bump_position();
        if (pr_pos != '1)
            pr_pos = pr_pos + 1'b1;
    endfunction

    // Advance the parse by one character; return 1 when it ends the string.
    function automatic bit parse_char(input stip_pkg::char_item_t item,
                                      output stip_pkg::result_item_t res);
        logic [7:0] ch;
        logic [6:0] dv;
        ch  = item.character;
        res = '0;
        if (item.string_start)
        begin
            pr_phase = stip_pkg::PH_LEAD;
            pr_base  = radix_reg;
            pr_acc   = '0;
            pr_neg   = 1'b0;
            pr_any   = 1'b0;
            pr_pos   = '0;
        end
        if (pr_phase == stip_pkg::PH_DONE)
            return 1'b0;
        if (pr_phase == stip_pkg::PH_LEAD)
        begin
            if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR))
            begin
                bump_position();
                return 1'b0;
            end
            pr_phase = stip_pkg::PH_SIGNED;
            if (ch == stip_pkg::CH_PLUS || ch == stip_pkg::CH_MINUS)
            begin
                pr_neg = (ch == stip_pkg::CH_MINUS);
                bump_position();
                return 1'b0;
            end
        end
        if (pr_phase == stip_pkg::PH_SIGNED)
        begin
            if (ch == stip_pkg::CH_ZERO &&
                (pr_base == stip_pkg::BASE_AUTO || pr_base == stip_pkg::BASE_BIN ||
                 pr_base == stip_pkg::BASE_HEX))
            begin
                bump_position();
                pr_phase = stip_pkg::PH_ZERO;
                return 1'b0;
            end
            if (pr_base == stip_pkg::BASE_AUTO)
                pr_base = stip_pkg::BASE_DEC;
            pr_phase = stip_pkg::PH_DIGITS;
        end
        else if (pr_phase == stip_pkg::PH_ZERO)
        begin
            if ((ch == stip_pkg::CH_X_LO || ch == stip_pkg::CH_X_UP) &&
                (pr_base == stip_pkg::BASE_AUTO || pr_base == stip_pkg::BASE_HEX))
            begin
                pr_base  = stip_pkg::BASE_HEX;
                pr_phase = stip_pkg::PH_DIGITS;
                bump_position();
                return 1'b0;
            end
            if ((ch == stip_pkg::CH_B_LO || ch == stip_pkg::CH_B_UP) &&
                (pr_base == stip_pkg::BASE_AUTO || pr_base == stip_pkg::BASE_BIN))
            begin
                pr_base  = stip_pkg::BASE_BIN;
                pr_phase = stip_pkg::PH_DIGITS;
                bump_position();
                return 1'b0;
            end
            // the zero was a digit after all; in auto radix it selects octal
            if (pr_base == stip_pkg::BASE_AUTO)
                pr_base = stip_pkg::BASE_OCT;
            pr_acc   = '0;
            pr_any   = 1'b1;
            pr_phase = stip_pkg::PH_DIGITS;
        end
        dv = char_digit(ch);
        if (dv < 7'(pr_base))
        begin
            pr_acc = pr_acc * 64'(pr_base) + 64'(dv);
            pr_any = 1'b1;
            bump_position();
            return 1'b0;
        end
        res.parsed_value   = pr_neg ? -pr_acc : pr_acc;
        res.consumed_count = pr_any ? pr_pos : 16'd0;
        res.digits_seen    = pr_any;
        res.minus_seen     = pr_neg;
        pr_phase = stip_pkg::PH_DONE;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        error_count++;
        if (error_count <= 50)
            $display("%0t ns: %s mismatch: got %h, want %h", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin : scoreboard
        stip_pkg::result_item_t res;
        stip_pkg::result_item_t want;
        bit                     produced;
        if (rst_n)
        begin
            if (char_valid && char_ready)
            begin
                if (char_data.string_start || pr_phase != stip_pkg::PH_DONE)
                    parsed_chars++;
                produced = parse_char(char_data, res);
                if (row_typed)
                    pending_results.push_back(row_want);
                else if (produced)
                    pending_results.push_back(res);
            end
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                    flag_mismatch("unexpected result, parsed_value", result_data.parsed_value, '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (result_data.parsed_value !== want.parsed_value)
                        flag_mismatch("parsed_value", result_data.parsed_value,
                                      want.parsed_value);
                    if (result_data.consumed_count !== want.consumed_count)
                        flag_mismatch("consumed_count", 64'(result_data.consumed_count),
                                      64'(want.consumed_count));
                    if (result_data.digits_seen !== want.digits_seen)
                        flag_mismatch("digits_seen", 64'(result_data.digits_seen),
                                      64'(want.digits_seen));
                    if (result_data.minus_seen !== want.minus_seen)
                        flag_mismatch("minus_seen", 64'(result_data.minus_seen),
                                      64'(want.minus_seen));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : receiver
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // hold off long enough for the parser to back up into its input
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic offer_char(input stip_pkg::char_item_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            @(negedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= item;
        do @(posedge clk); while (!char_ready);
        @(negedge clk);
    endtask

    task automatic drain_results();
        char_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_base(input logic [5:0] value);
        drain_results();
        base_we    <= 1'b1;
        base_wdata <= value;
        @(negedge clk);
        base_we   <= 1'b0;
        radix_reg = value;
    endtask

    // Build one string: blanks, sign, prefix, digits, terminator (dropped when cut).
    task automatic send_string(input bit cut);
        stip_pkg::char_item_t seq [$];
        int                   pre;
        int                   radix;
        int                   dmax;
        int                   n;
        int                   dv;
        bit                   maxed;
        logic [7:0]           ch;
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3))
            begin
                ch = ($urandom_range(5) == 0) ? CH_SPACE : 8'(CH_TAB + $urandom_range(4));
                seq.push_back(stip_pkg::char_item_t'{ch, 1'b0});
            end
        case ($urandom_range(3))
            0: seq.push_back(stip_pkg::char_item_t'{stip_pkg::CH_PLUS, 1'b0});
            1: seq.push_back(stip_pkg::char_item_t'{stip_pkg::CH_MINUS, 1'b0});
            default: ;
        endcase
        pre = $urandom_range(9);
        // mostly keep the prefix consistent with the radix
        if ($urandom_range(4) != 0)
        begin
            if (pre <= 1 && radix_reg != stip_pkg::BASE_AUTO &&
                radix_reg != stip_pkg::BASE_HEX)
                pre = 9;
            if ((pre == 2 || pre == 3) && radix_reg != stip_pkg::BASE_AUTO &&
                radix_reg != stip_pkg::BASE_BIN)
                pre = 9;
        end
        if (pre <= 4)
            seq.push_back(stip_pkg::char_item_t'{stip_pkg::CH_ZERO, 1'b0});
        case (pre)
            0: seq.push_back(stip_pkg::char_item_t'{stip_pkg::CH_X_LO, 1'b0});
            1: seq.push_back(stip_pkg::char_item_t'{stip_pkg::CH_X_UP, 1'b0});
            2: seq.push_back(stip_pkg::char_item_t'{stip_pkg::CH_B_LO, 1'b0});
            3: seq.push_back(stip_pkg::char_item_t'{stip_pkg::CH_B_UP, 1'b0});
            default: ;
        endcase
        radix = radix_reg;
        if (radix_reg == stip_pkg::BASE_AUTO)
            radix = (pre <= 1) ? stip_pkg::BASE_HEX :
                    (pre <= 3) ? stip_pkg::BASE_BIN :
                    (pre == 4) ? stip_pkg::BASE_OCT : stip_pkg::BASE_DEC;
        dmax  = ((radix > 36) ? 36 : radix) - 1;
        n     = ($urandom_range(19) == 0) ? $urandom_range(20, 70) : $urandom_range(12);
        maxed = ($urandom_range(9) == 0);
        repeat (n)
        begin
            dv = maxed ? dmax : $urandom_range(dmax);
            if (dv < 10)
                ch = 8'(stip_pkg::CH_ZERO + dv);
            else
                ch = 8'((($urandom_range(1) == 0) ? CH_A_LO : CH_A_UP) + dv - 10);
            seq.push_back(stip_pkg::char_item_t'{ch, 1'b0});
        end
        if (!cut)
            seq.push_back(stip_pkg::char_item_t'{8'($urandom_range(255)), 1'b0});
        if (seq.size() == 0)
            return;
        seq[0].string_start = 1'b1;
        foreach (seq[i])
            offer_char(seq[i]);
    endtask

    initial
    begin : stimulus
        int mode;
        int goal;
        int pick;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_table[i])
        begin
            if (dir_table[i].load_base)
                load_base(dir_table[i].base);
            row_typed = dir_table[i].typed;
            row_want  = dir_table[i].want;
            offer_char(dir_table[i].item);
        end
        row_typed = 1'b0;

        // one long decimal string that wraps the accumulator several times
        load_base(stip_pkg::BASE_DEC);
        offer_char(stip_pkg::char_item_t'{"7", 1'b1});
        repeat (LONG_DIGITS)
            offer_char(stip_pkg::char_item_t'{8'(stip_pkg::CH_ZERO + $urandom_range(9)), 1'b0});
        offer_char(stip_pkg::char_item_t'{".", 1'b0});

        for (int p = 0; p < 10; p++)
        begin
            load_base((p == 9) ? 6'($urandom_range(63)) : phase_bases[p]);
            mode           = p % 4;
            send_idle_pct  = send_pct_by_mode[mode];
            recv_stall_pct = recv_pct_by_mode[mode];
            if (p == 0)
                hold_req = 1'b1;
            goal = parsed_chars + PHASE_CHARS;
            while (parsed_chars < goal)
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                    send_string(1'b0);
                else if (pick < 85)
                    send_string(1'b1);
                else
                    repeat ($urandom_range(1, 4))
                        offer_char(stip_pkg::char_item_t'{8'($urandom_range(255)),
                                                          1'($urandom_range(3) == 0)});
            end
        end

        drain_results();
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
